>>> hw/rtl/sri_pkg.sv
// ---------------------------------------------------------------------------
// sri_pkg: shared constants for the segment/rectangle hit test
// Coordinate width default.
// ---------------------------------------------------------------------------
package sri_pkg;
  localparam int unsigned CoordBitsDef = 16;
endpackage

>>> hw/rtl/segment_rect_intersection.sv
// ---------------------------------------------------------------------------
// segment_rect_intersection: segment versus axis-aligned rectangle hit test
// Exact integer test: containment of both endpoints, or a crossing of any
// of the rectangle edges decided by cross-multiplied compares.
// ---------------------------------------------------------------------------
// Channel | Direction | Transaction marker
// in_     | input     | start high while busy low
// out_    | output    | out_valid high for one cycle
// out_valid follows start through the register stages below; one transaction each cycle.
// Four register stages: edge differences, products, compares, result.
// busy is held low: the pipeline never stalls since the receiver cannot.
// Synchronous active-low reset clears the valid bits only.
module segment_rect_intersection
  import sri_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_seg_start_x,
  input  logic signed [COORD_BITS-1:0] in_seg_start_y,
  input  logic signed [COORD_BITS-1:0] in_seg_end_x,
  input  logic signed [COORD_BITS-1:0] in_seg_end_y,
  input  logic signed [COORD_BITS-1:0] in_box_left,
  input  logic signed [COORD_BITS-1:0] in_box_top,
  input  logic        [COORD_BITS-2:0] in_box_width,
  input  logic        [COORD_BITS-2:0] in_box_height,
  output logic                         out_valid,
  output logic                         out_hit
);
  localparam int unsigned W  = COORD_BITS;
  localparam int unsigned DW = W + 2;      // differences
  localparam int unsigned PW = 2 * DW;     // products

  typedef logic signed [DW-1:0] d_t;
  typedef logic signed [PW-1:0] p_t;

  // stage 1: per-edge operands
  logic       v1_r;
  logic       inside_r;
  logic [3:0] ok1_r;
  d_t         a_r [4];   // vlo - v1
  d_t         bm_r [4];  // e - u1
  d_t         c_r [4];   // vhi - v1
  d_t         du_r [4];
  d_t         dv_r [4];

  logic       v2_r, inside2_r;
  logic [3:0] ok2_r;
  p_t         lo_r [4], mid_r [4], hi_r [4];

  logic       v3_r, inside3_r;
  logic [3:0] cr_r;

  logic       v4_r, hit_r;

  assign busy = 1'b0;

  // stage 1: sort endpoints per edge and form differences
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [DW-1:0] x1, y1, x2, y2, l, t, r, b;
    logic signed [DW-1:0] u1, v1, u2, v2, e, vlo, vhi, tu, tv;
    x1 = DW'(in_seg_start_x); y1 = DW'(in_seg_start_y);
    x2 = DW'(in_seg_end_x);   y2 = DW'(in_seg_end_y);
    l  = DW'(in_box_left);    t  = DW'(in_box_top);
    r  = l + $signed({2'b00, in_box_width});
    b  = t + $signed({2'b00, in_box_height});
    inside_r <= x1 >= l && x1 <= r && x2 >= l && x2 <= r &&
                y1 >= t && y1 <= b && y2 >= t && y2 <= b;
    for (int i = 0; i < 4; i++) begin
      if (i == 0 || i == 3) begin
        u1 = y1; v1 = x1; u2 = y2; v2 = x2; vlo = l; vhi = r;
        e = (i == 0) ? t : b;
      end else begin
        u1 = x1; v1 = y1; u2 = x2; v2 = y2; vlo = t; vhi = b;
        e = (i == 1) ? l : r;
      end
      if (u1 > u2) begin
        tu = u1; u1 = u2; u2 = tu;
        tv = v1; v1 = v2; v2 = tv;
      end
      ok1_r[i] <= (u1 != u2) && (e >= u1) && (e <= u2) &&
                  ((i == 0 || i == 3) ? (in_box_width != '0)
                                      : (in_box_height != '0));
      a_r[i]  <= vlo - v1;
      bm_r[i] <= e - u1;
      c_r[i]  <= vhi - v1;
      du_r[i] <= u2 - u1;
      dv_r[i] <= v2 - v1;
    end
  end

  // stage 2: products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    inside2_r <= inside_r;
    ok2_r     <= ok1_r;
    for (int i = 0; i < 4; i++) begin
      lo_r[i]  <= PW'(a_r[i])  * PW'(du_r[i]);
      mid_r[i] <= PW'(bm_r[i]) * PW'(dv_r[i]);
      hi_r[i]  <= PW'(c_r[i])  * PW'(du_r[i]);
    end
  end

  // stage 3: compares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    inside3_r <= inside2_r;
    for (int i = 0; i < 4; i++) begin
      cr_r[i] <= ok2_r[i] && (lo_r[i] <= mid_r[i]) && (mid_r[i] <= hi_r[i]);
    end
  end

  // stage 4: combine into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= inside3_r || (|cr_r);
  end

  assign out_valid = v4_r;
  assign out_hit   = hit_r;

  // every start comes out as out_valid once it has passed the pipeline registers
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##4 out_valid) else $error("result latency broken");
  a_nostart: assert property (@(posedge clk) disable iff (!rst_n)
    !start |-> ##4 !out_valid) else $error("spurious result");
  a_v2: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |=> v3_r) else $error("valid lost in pipeline");
endmodule
